// File: rtl/prim_mst_pkg.sv
`default_nettype none

package prim_mst_pkg;

    localparam int VTX_W  = 10;
    localparam int WT_W   = 16;
    localparam int COST_W = 26;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    localparam logic       REG_VERTEX_COUNT = 1'b0;
    localparam logic [9:0] VC_RESET         = 10'd1;

    typedef struct packed {
        logic [VTX_W-1:0]       tgt;
        logic signed [WT_W-1:0] wt;
    } arc_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ITEM,
        ST_LINK_A,
        ST_LINK_B,
        ST_RUN_INIT,
        ST_CHECK,
        ST_POP_RD,
        ST_POP_TOP,
        ST_POP_MOVED,
        ST_SD_RD,
        ST_SD_LEFT,
        ST_SD_RIGHT,
        ST_SD_CMP,
        ST_VISIT_RD,
        ST_VISIT_CHK,
        ST_ARC_HEAD,
        ST_ARC_RD,
        ST_ARC_VIS,
        ST_ARC_CHK,
        ST_PUSH_RD,
        ST_PUSH_CMP,
        ST_DONE
    } ctrl_state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_ITEM,
        OP_LINK_A,
        OP_LINK_B,
        OP_RUN_INIT,
        OP_POP_RD,
        OP_POP_TOP,
        OP_POP_MOVED,
        OP_SD_RD,
        OP_SD_LEFT,
        OP_SD_RIGHT,
        OP_SD_CMP,
        OP_VISIT_RD,
        OP_VISIT_CHK,
        OP_ARC_HEAD,
        OP_ARC_RD,
        OP_ARC_VIS,
        OP_ARC_CHK,
        OP_PUSH_RD,
        OP_PUSH_CMP
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   accept;
        logic   out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic item_edge;
        logic item_last;
        logic full;
        logic clr_last;
        logic heap_empty;
        logic rem_zero;
        logic size_zero;
        logic c_ge_size;
        logic has_right;
        logic sift_stop;
        logic visited;
        logic e_zero;
        logic push_ok;
        logic i_zero;
        logic push_stop;
    } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/prim_mst_ctrl.sv
`default_nettype none

module prim_mst_ctrl (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    output logic                    in_stall,
    output logic                    out_valid,
    input  wire                     out_stall,
    input  wire prim_mst_pkg::dp_status_t st,
    output prim_mst_pkg::dp_cmd_t    cmd
);

    prim_mst_pkg::ctrl_state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= prim_mst_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = prim_mst_pkg::OP_NONE;
        cmd.accept   = 1'b0;
        cmd.out_load = 1'b0;
        in_stall     = 1'b1;
        unique case (state_reg)
            prim_mst_pkg::ST_CLEAR:
            begin
                cmd.op = prim_mst_pkg::OP_CLEAR;
                if (st.clr_last)
                    state_next = prim_mst_pkg::ST_IDLE;
            end
            prim_mst_pkg::ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
                if (in_valid)
                    state_next = prim_mst_pkg::ST_ITEM;
            end
            prim_mst_pkg::ST_ITEM:
            begin
                cmd.op = prim_mst_pkg::OP_ITEM;
                priority if (st.item_edge && !st.full)
                    state_next = prim_mst_pkg::ST_LINK_A;
                else if (st.item_last)
                    state_next = prim_mst_pkg::ST_RUN_INIT;
                else
                    state_next = prim_mst_pkg::ST_IDLE;
            end
            prim_mst_pkg::ST_LINK_A:
            begin
                cmd.op     = prim_mst_pkg::OP_LINK_A;
                state_next = prim_mst_pkg::ST_LINK_B;
            end
            prim_mst_pkg::ST_LINK_B:
            begin
                cmd.op     = prim_mst_pkg::OP_LINK_B;
                state_next = st.item_last ? prim_mst_pkg::ST_RUN_INIT
                                          : prim_mst_pkg::ST_IDLE;
            end
            prim_mst_pkg::ST_RUN_INIT:
            begin
                cmd.op     = prim_mst_pkg::OP_RUN_INIT;
                state_next = prim_mst_pkg::ST_CHECK;
            end
            prim_mst_pkg::ST_CHECK:
            begin
                state_next = (st.heap_empty || st.rem_zero) ? prim_mst_pkg::ST_DONE
                                                            : prim_mst_pkg::ST_POP_RD;
            end
            prim_mst_pkg::ST_POP_RD:
            begin
                cmd.op     = prim_mst_pkg::OP_POP_RD;
                state_next = prim_mst_pkg::ST_POP_TOP;
            end
            prim_mst_pkg::ST_POP_TOP:
            begin
                cmd.op     = prim_mst_pkg::OP_POP_TOP;
                state_next = st.size_zero ? prim_mst_pkg::ST_VISIT_RD
                                          : prim_mst_pkg::ST_POP_MOVED;
            end
            prim_mst_pkg::ST_POP_MOVED:
            begin
                cmd.op     = prim_mst_pkg::OP_POP_MOVED;
                state_next = prim_mst_pkg::ST_SD_RD;
            end
            prim_mst_pkg::ST_SD_RD:
            begin
                cmd.op     = prim_mst_pkg::OP_SD_RD;
                state_next = st.c_ge_size ? prim_mst_pkg::ST_VISIT_RD
                                          : prim_mst_pkg::ST_SD_LEFT;
            end
            prim_mst_pkg::ST_SD_LEFT:
            begin
                cmd.op     = prim_mst_pkg::OP_SD_LEFT;
                state_next = st.has_right ? prim_mst_pkg::ST_SD_RIGHT
                                          : prim_mst_pkg::ST_SD_CMP;
            end
            prim_mst_pkg::ST_SD_RIGHT:
            begin
                cmd.op     = prim_mst_pkg::OP_SD_RIGHT;
                state_next = prim_mst_pkg::ST_SD_CMP;
            end
            prim_mst_pkg::ST_SD_CMP:
            begin
                cmd.op     = prim_mst_pkg::OP_SD_CMP;
                state_next = st.sift_stop ? prim_mst_pkg::ST_VISIT_RD
                                          : prim_mst_pkg::ST_SD_RD;
            end
            prim_mst_pkg::ST_VISIT_RD:
            begin
                cmd.op     = prim_mst_pkg::OP_VISIT_RD;
                state_next = prim_mst_pkg::ST_VISIT_CHK;
            end
            prim_mst_pkg::ST_VISIT_CHK:
            begin
                cmd.op     = prim_mst_pkg::OP_VISIT_CHK;
                state_next = st.visited ? prim_mst_pkg::ST_CHECK
                                        : prim_mst_pkg::ST_ARC_HEAD;
            end
            prim_mst_pkg::ST_ARC_HEAD:
            begin
                cmd.op     = prim_mst_pkg::OP_ARC_HEAD;
                state_next = prim_mst_pkg::ST_ARC_RD;
            end
            prim_mst_pkg::ST_ARC_RD:
            begin
                cmd.op     = prim_mst_pkg::OP_ARC_RD;
                state_next = st.e_zero ? prim_mst_pkg::ST_CHECK
                                       : prim_mst_pkg::ST_ARC_VIS;
            end
            prim_mst_pkg::ST_ARC_VIS:
            begin
                cmd.op     = prim_mst_pkg::OP_ARC_VIS;
                state_next = prim_mst_pkg::ST_ARC_CHK;
            end
            prim_mst_pkg::ST_ARC_CHK:
            begin
                cmd.op     = prim_mst_pkg::OP_ARC_CHK;
                state_next = st.push_ok ? prim_mst_pkg::ST_PUSH_RD
                                        : prim_mst_pkg::ST_ARC_RD;
            end
            prim_mst_pkg::ST_PUSH_RD:
            begin
                cmd.op     = prim_mst_pkg::OP_PUSH_RD;
                state_next = st.i_zero ? prim_mst_pkg::ST_ARC_RD
                                       : prim_mst_pkg::ST_PUSH_CMP;
            end
            prim_mst_pkg::ST_PUSH_CMP:
            begin
                cmd.op     = prim_mst_pkg::OP_PUSH_CMP;
                state_next = st.push_stop ? prim_mst_pkg::ST_ARC_RD
                                          : prim_mst_pkg::ST_PUSH_RD;
            end
            prim_mst_pkg::ST_DONE:
            begin
                cmd.out_load = slot_free;
                if (slot_free)
                    state_next = prim_mst_pkg::ST_CLEAR;
            end
            default:
                state_next = prim_mst_pkg::ST_CLEAR;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (cmd.out_load)
            out_valid_next = 1'b1;
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: rtl/prim_mst_dp.sv
`default_nettype none

module prim_mst_dp #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_EDGES    = 4096
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      edge_valid,
    input  wire  [9:0]               endpoint_a,
    input  wire  [9:0]               endpoint_b,
    input  wire  signed [15:0]       weight,
    input  wire                      last_edge,
    input  wire  [9:0]               vertex_count,
    input  wire prim_mst_pkg::dp_cmd_t cmd,
    output prim_mst_pkg::dp_status_t st,
    output logic signed [25:0]       total_cost,
    output logic                     not_connected,
    output logic                     edge_overflow
);

    localparam int VW   = $clog2(MAX_VERTICES);
    localparam int EDEP = 2 * MAX_EDGES;
    localparam int SW   = $clog2(EDEP);
    localparam int PW   = $clog2(EDEP + 1);
    localparam int NW   = $clog2(MAX_EDGES + 1);
    localparam int HD   = EDEP + 1;
    localparam int HIW  = $clog2(HD);
    localparam int HSW  = $clog2(HD + 1);
    localparam int CW   = prim_mst_pkg::COST_W;
    localparam int WW   = prim_mst_pkg::WT_W;

    // memories
    prim_mst_pkg::arc_t edge_mem [EDEP];
    logic [PW-1:0]      next_mem [EDEP];
    logic [PW-1:0]      head_mem [MAX_VERTICES];
    logic               vis_mem  [MAX_VERTICES];
    prim_mst_pkg::arc_t heap_mem [HD];

    prim_mst_pkg::arc_t edge_q, heap_q;
    logic [PW-1:0]      next_q, head_q;
    logic               vis_q;

    // item and run registers
    logic               ev_reg, last_reg;
    logic [9:0]         a_reg, b_reg;
    logic signed [15:0] w_reg;
    logic [NW-1:0]      n_reg, n_next;
    logic               ovf_reg, ovf_next;
    logic [VW-1:0]      clr_reg, clr_next;
    logic [HSW-1:0]     size_reg, size_next;
    logic [HIW-1:0]     i_reg, i_next;
    logic [HIW-1:0]     cidx_reg, cidx_next;
    prim_mst_pkg::arc_t child_reg, child_next;
    prim_mst_pkg::arc_t top_reg, top_next;
    prim_mst_pkg::arc_t moved_reg, moved_next;
    prim_mst_pkg::arc_t arc_reg, arc_next;
    logic [PW-1:0]      e_reg, e_next;
    logic [9:0]         rem_reg, rem_next;
    logic [CW-1:0]      cost_reg, cost_next;

    // memory port controls
    logic               head_we, vis_we, edge_we, next_we, heap_we;
    logic [VW-1:0]      head_wa, head_ra, vis_wa, vis_ra;
    logic [PW-1:0]      head_wd;
    logic               vis_wd;
    logic [SW-1:0]      edge_wa, edge_ra;
    prim_mst_pkg::arc_t edge_wd, heap_wd;
    logic [PW-1:0]      next_wd;
    logic [HIW-1:0]     heap_wa, heap_ra;

    logic               a_ok, b_ok;
    logic [HIW:0]       c_full;
    logic [HIW-1:0]     p_idx;
    logic               tgt_ok;

    assign a_ok   = 32'(a_reg) < MAX_VERTICES;
    assign b_ok   = 32'(b_reg) < MAX_VERTICES;
    assign c_full = {i_reg, 1'b1};
    assign p_idx  = HIW'((i_reg - HIW'(1)) >> 1);
    assign tgt_ok = (arc_reg.tgt != 10'd0) && (arc_reg.tgt <= vertex_count)
                    && (32'(arc_reg.tgt) < MAX_VERTICES);

    always_ff @(posedge clk)
    begin
        if (head_we)
            head_mem[head_wa] <= head_wd;
        head_q <= head_mem[head_ra];
    end

    always_ff @(posedge clk)
    begin
        if (vis_we)
            vis_mem[vis_wa] <= vis_wd;
        vis_q <= vis_mem[vis_ra];
    end

    always_ff @(posedge clk)
    begin
        if (edge_we)
            edge_mem[edge_wa] <= edge_wd;
        edge_q <= edge_mem[edge_ra];
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
            next_mem[edge_wa] <= next_wd;
        next_q <= next_mem[edge_ra];
    end

    always_ff @(posedge clk)
    begin
        if (heap_we)
            heap_mem[heap_wa] <= heap_wd;
        heap_q <= heap_mem[heap_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            ev_reg   <= edge_valid;
            a_reg    <= endpoint_a;
            b_reg    <= endpoint_b;
            w_reg    <= weight;
            last_reg <= last_edge;
        end
        size_reg  <= size_next;
        i_reg     <= i_next;
        cidx_reg  <= cidx_next;
        child_reg <= child_next;
        top_reg   <= top_next;
        moved_reg <= moved_next;
        arc_reg   <= arc_next;
        e_reg     <= e_next;
        rem_reg   <= rem_next;
        cost_reg  <= cost_next;
        if (cmd.out_load)
        begin
            total_cost    <= signed'(cost_reg);
            not_connected <= rem_reg != 10'd0;
            edge_overflow <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg   <= '0;
            ovf_reg <= 1'b0;
            clr_reg <= '0;
        end
        else
        begin
            n_reg   <= n_next;
            ovf_reg <= ovf_next;
            clr_reg <= clr_next;
        end
    end

    always_comb
    begin
        n_next     = n_reg;
        ovf_next   = ovf_reg;
        clr_next   = clr_reg;
        size_next  = size_reg;
        i_next     = i_reg;
        cidx_next  = cidx_reg;
        child_next = child_reg;
        top_next   = top_reg;
        moved_next = moved_reg;
        arc_next   = arc_reg;
        e_next     = e_reg;
        rem_next   = rem_reg;
        cost_next  = cost_reg;

        head_we = 1'b0;
        head_wa = VW'(a_reg);
        head_wd = '0;
        head_ra = VW'(a_reg);
        vis_we  = 1'b0;
        vis_wa  = VW'(top_reg.tgt);
        vis_wd  = 1'b0;
        vis_ra  = VW'(top_reg.tgt);
        edge_we = 1'b0;
        next_we = 1'b0;
        edge_wa = SW'({n_reg, 1'b0});
        edge_wd = '{tgt: b_reg, wt: w_reg};
        next_wd = head_q;
        edge_ra = SW'(e_reg - PW'(1));
        heap_we = 1'b0;
        heap_wa = i_reg;
        heap_wd = moved_reg;
        heap_ra = '0;

        if (cmd.out_load)
        begin
            n_next   = '0;
            ovf_next = 1'b0;
        end

        unique case (cmd.op)
            prim_mst_pkg::OP_NONE:
            begin
            end
            prim_mst_pkg::OP_CLEAR:
            begin
                head_we = 1'b1;
                head_wa = clr_reg;
                vis_we  = 1'b1;
                vis_wa  = clr_reg;
                clr_next = (clr_reg == VW'(MAX_VERTICES - 1)) ? '0 : clr_reg + VW'(1);
            end
            prim_mst_pkg::OP_ITEM:
            begin
                if (ev_reg && 32'(n_reg) >= MAX_EDGES)
                    ovf_next = 1'b1;
            end
            prim_mst_pkg::OP_LINK_A:
            begin
                edge_we = 1'b1;
                next_we = a_ok;
                head_we = a_ok;
                head_wd = PW'({n_reg, 1'b1});
                head_ra = VW'(b_reg);
            end
            prim_mst_pkg::OP_LINK_B:
            begin
                edge_we = 1'b1;
                edge_wa = SW'({n_reg, 1'b1});
                edge_wd = '{tgt: a_reg, wt: w_reg};
                next_we = b_ok;
                next_wd = (a_ok && a_reg == b_reg) ? PW'({n_reg, 1'b1}) : head_q;
                head_we = b_ok;
                head_wa = VW'(b_reg);
                head_wd = PW'({n_reg, 1'b0}) + PW'(2);
                n_next  = n_reg + NW'(1);
            end
            prim_mst_pkg::OP_RUN_INIT:
            begin
                rem_next  = vertex_count;
                cost_next = '0;
                size_next = HSW'(1);
                heap_we   = 1'b1;
                heap_wa   = '0;
                heap_wd   = '{tgt: 10'd1, wt: '0};
            end
            prim_mst_pkg::OP_POP_RD:
            begin
                heap_ra   = '0;
                size_next = size_reg - HSW'(1);
            end
            prim_mst_pkg::OP_POP_TOP:
            begin
                top_next = heap_q;
                heap_ra  = HIW'(size_reg);
            end
            prim_mst_pkg::OP_POP_MOVED:
            begin
                moved_next = heap_q;
                i_next     = '0;
            end
            prim_mst_pkg::OP_SD_RD:
            begin
                heap_ra   = HIW'(c_full);
                cidx_next = HIW'(c_full);
                heap_we   = 32'(c_full) >= 32'(size_reg);
            end
            prim_mst_pkg::OP_SD_LEFT:
            begin
                child_next = heap_q;
                heap_ra    = cidx_reg + HIW'(1);
            end
            prim_mst_pkg::OP_SD_RIGHT:
            begin
                if (heap_q.wt < child_reg.wt)
                begin
                    child_next = heap_q;
                    cidx_next  = cidx_reg + HIW'(1);
                end
            end
            prim_mst_pkg::OP_SD_CMP:
            begin
                heap_we = 1'b1;
                if (moved_reg.wt > child_reg.wt)
                begin
                    heap_wd = child_reg;
                    i_next  = cidx_reg;
                end
            end
            prim_mst_pkg::OP_VISIT_RD:
            begin
                vis_ra = VW'(top_reg.tgt);
            end
            prim_mst_pkg::OP_VISIT_CHK:
            begin
                head_ra = VW'(top_reg.tgt);
                if (!vis_q)
                begin
                    vis_we    = 1'b1;
                    vis_wd    = 1'b1;
                    rem_next  = rem_reg - 10'd1;
                    cost_next = cost_reg + {{(CW - WW){top_reg.wt[WW-1]}}, top_reg.wt};
                end
            end
            prim_mst_pkg::OP_ARC_HEAD:
            begin
                e_next = head_q;
            end
            prim_mst_pkg::OP_ARC_RD:
            begin
                edge_ra = SW'(e_reg - PW'(1));
            end
            prim_mst_pkg::OP_ARC_VIS:
            begin
                arc_next = edge_q;
                e_next   = next_q;
                vis_ra   = VW'(edge_q.tgt);
            end
            prim_mst_pkg::OP_ARC_CHK:
            begin
                if (st.push_ok)
                begin
                    i_next    = HIW'(size_reg);
                    size_next = size_reg + HSW'(1);
                end
            end
            prim_mst_pkg::OP_PUSH_RD:
            begin
                heap_ra = p_idx;
                heap_wd = arc_reg;
                heap_we = i_reg == '0;
            end
            prim_mst_pkg::OP_PUSH_CMP:
            begin
                heap_we = 1'b1;
                if (heap_q.wt <= arc_reg.wt)
                    heap_wd = arc_reg;
                else
                begin
                    heap_wd = heap_q;
                    i_next  = p_idx;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        st.item_edge  = ev_reg;
        st.item_last  = last_reg;
        st.full       = 32'(n_reg) >= MAX_EDGES;
        st.clr_last   = clr_reg == VW'(MAX_VERTICES - 1);
        st.heap_empty = size_reg == '0;
        st.rem_zero   = rem_reg == 10'd0;
        st.size_zero  = size_reg == '0;
        st.c_ge_size  = 32'(c_full) >= 32'(size_reg);
        st.has_right  = 32'(cidx_reg) + 1 < 32'(size_reg);
        st.sift_stop  = moved_reg.wt <= child_reg.wt;
        st.visited    = vis_q;
        st.e_zero     = e_reg == '0;
        st.push_ok    = tgt_ok && !vis_q && (32'(size_reg) < HD);
        st.i_zero     = i_reg == '0;
        st.push_stop  = heap_q.wt <= arc_reg.wt;
    end

endmodule

`default_nettype wire

// File: rtl/prim_mst_weight_core.sv
// Minimum spanning tree weight engine (Prim, binary min-heap of edges).
// Input channel: one request per item (edge_valid, endpoint_a, endpoint_b,
// weight, last_edge) on in_valid / in_stall. Each edge is linked into the
// adjacency lists of both endpoints; a stored edge passes the item state and
// both link states before the next acceptance, a marker or a dropped edge
// only the item state. The request with last_edge set starts the tree search
// from vertex 1. It runs over the heap and adjacency memories, reading each
// adjacency entry in turn and sifting the heap level by level on each push
// and pop. One result request (total_cost, not_connected, edge_overflow)
// follows on out_valid / out_stall, then the list heads and visited map are
// cleared before the next request is taken. Reset starts the same clearing
// sweep (in_stall high); vertex_count returns to 1. The result sits in an
// output register: while the receiver stalls it holds, and new edges are
// still accepted; a second result waits in the final state until the first
// has been taken. vertex_count is written over the APB-style port when paddr[2]
// is 0; the user writes it only while idle, which the block does not enforce.

`default_nettype none

module prim_mst_weight_core #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_EDGES    = 4096
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   in_valid,
    output logic                                  in_stall,
    input  wire                                   edge_valid,
    input  wire  [9:0]                            endpoint_a,
    input  wire  [9:0]                            endpoint_b,
    input  wire  signed [15:0]                    weight,
    input  wire                                   last_edge,
    output logic                                  out_valid,
    input  wire                                   out_stall,
    output logic signed [25:0]                    total_cost,
    output logic                                  not_connected,
    output logic                                  edge_overflow,
    input  wire                                   psel,
    input  wire                                   penable,
    input  wire                                   pwrite,
    input  wire  [prim_mst_pkg::ADDR_W-1:0]       paddr,
    input  wire  [prim_mst_pkg::DATA_W-1:0]       pwdata,
    output logic [prim_mst_pkg::DATA_W-1:0]       prdata,
    output logic                                  pready
);

    logic [9:0] vc_reg, vc_next;
    prim_mst_pkg::dp_cmd_t    cmd;
    prim_mst_pkg::dp_status_t st;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vc_reg <= prim_mst_pkg::VC_RESET;
        else
            vc_reg <= vc_next;
    end

    always_comb
    begin
        vc_next = vc_reg;
        if (psel && penable && pwrite && pready
            && paddr[2] == prim_mst_pkg::REG_VERTEX_COUNT)
            vc_next = pwdata[9:0];
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == prim_mst_pkg::REG_VERTEX_COUNT)
            prdata = {{(prim_mst_pkg::DATA_W - 10){1'b0}}, vc_reg};
    end

    prim_mst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .st        (st),
        .cmd       (cmd)
    );

    prim_mst_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .edge_valid    (edge_valid),
        .endpoint_a    (endpoint_a),
        .endpoint_b    (endpoint_b),
        .weight        (weight),
        .last_edge     (last_edge),
        .vertex_count  (vc_reg),
        .cmd           (cmd),
        .st            (st),
        .total_cost    (total_cost),
        .not_connected (not_connected),
        .edge_overflow (edge_overflow)
    );

endmodule

`default_nettype wire

// File: rtl/prim_mst_chk.sv
`default_nettype none

module prim_mst_chk (
    input wire               clk,
    input wire               rst_n,
    input wire               in_valid,
    input wire               in_stall,
    input wire               last_edge,
    input wire               out_valid,
    input wire               out_stall,
    input wire signed [25:0] total_cost,
    input wire               not_connected,
    input wire               edge_overflow
);

    a_reset_no_result: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result shown during reset");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(total_cost)
        && $stable(not_connected) && $stable(edge_overflow))
        else $error("stalled result changed");

    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_edge |=> in_stall)
        else $error("request taken during tree search");

    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_stall)
        else $error("result raised outside a run");

endmodule

bind prim_mst_weight_core prim_mst_chk u_chk (.*);

`default_nettype wire

// File: tb/prim_mst_checker.sv
`timescale 1ns / 100ps

module prim_mst_checker (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    input  wire                                 in_stall,
    input  wire                                 edge_valid,
    input  wire  [9:0]                          endpoint_a,
    input  wire  [9:0]                          endpoint_b,
    input  wire  signed [15:0]                  weight,
    input  wire                                 last_edge,
    input  wire                                 out_valid,
    input  wire                                 out_stall,
    input  wire  signed [25:0]                  total_cost,
    input  wire                                 not_connected,
    input  wire                                 edge_overflow,
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire  [prim_mst_pkg::ADDR_W-1:0]     paddr,
    input  wire  [prim_mst_pkg::DATA_W-1:0]     pwdata,
    input  wire                                 pready,
    output int                                  fails,
    output int                                  pending
);

    localparam int NUM_VTX   = 1024;
    localparam int NUM_EDGES = 4096;
    localparam int NUM_ARCS  = 2 * NUM_EDGES;

    typedef struct {
        logic signed [25:0] cost;
        logic               nc;
        logic               ovf;
    } tree_result_t;

    tree_result_t tree_q[$];

    logic [9:0]         vcount;
    logic [9:0]         arc_tgt [NUM_ARCS];
    int                 arc_wt  [NUM_ARCS];
    int unsigned        arc_nxt [NUM_ARCS];
    int unsigned        vhead   [NUM_VTX];
    bit                 vseen   [NUM_VTX];
    int unsigned        n_edges;
    bit                 dropped;
    logic [9:0]         hp_tgt  [NUM_ARCS + 1];
    int                 hp_wt   [NUM_ARCS + 1];
    int unsigned        hp_n;

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch: %s got %0d expected %0d", what, got, want);
        fails++;
    endtask

    function automatic void wipe_graph();
        for (int i = 0; i < NUM_VTX; i++)
        begin
            vhead[i] = 0;
            vseen[i] = 0;
        end
        n_edges = 0;
        dropped = 0;
        hp_n = 0;
    endfunction

    function automatic void add_arc(input logic [9:0] from, input logic [9:0] to,
                                    input int w, input int unsigned slot);
        arc_tgt[slot] = to;
        arc_wt[slot]  = w;
        arc_nxt[slot] = vhead[from];
        vhead[from]   = slot + 1;
    endfunction

    function automatic void heap_add(input logic [9:0] to, input int w);
        int unsigned i;
        int unsigned p;
        if (hp_n >= NUM_ARCS + 1)
            return;
        i = hp_n;
        hp_n++;
        while (i > 0)
        begin
            p = (i - 1) / 2;
            if (hp_wt[p] <= w)
                break;
            hp_tgt[i] = hp_tgt[p];
            hp_wt[i]  = hp_wt[p];
            i = p;
        end
        hp_tgt[i] = to;
        hp_wt[i]  = w;
    endfunction

    function automatic void heap_take(output logic [9:0] to, output int w);
        int unsigned i;
        int unsigned c;
        logic [9:0]  mt;
        int          mw;
        i  = 0;
        to = hp_tgt[0];
        w  = hp_wt[0];
        hp_n--;
        if (hp_n == 0)
            return;
        mt = hp_tgt[hp_n];
        mw = hp_wt[hp_n];
        forever
        begin
            c = 2 * i + 1;
            if (c >= hp_n)
                break;
            if (c + 1 < hp_n && hp_wt[c + 1] < hp_wt[c])
                c++;
            if (mw <= hp_wt[c])
                break;
            hp_tgt[i] = hp_tgt[c];
            hp_wt[i]  = hp_wt[c];
            i = c;
        end
        hp_tgt[i] = mt;
        hp_wt[i]  = mw;
    endfunction

    function automatic tree_result_t span_tree();
        tree_result_t r;
        int unsigned  left;
        int           sum;
        int unsigned  e;
        logic [9:0]   v;
        logic [9:0]   t;
        int           w;
        left = vcount;
        sum  = 0;
        hp_n = 0;
        heap_add(10'd1, 0);
        while (hp_n > 0 && left > 0)
        begin
            heap_take(v, w);
            if (vseen[v])
                continue;
            vseen[v] = 1;
            left--;
            sum += w;
            e = vhead[v];
            while (e != 0 && e <= NUM_ARCS)
            begin
                t = arc_tgt[e - 1];
                if (t >= 1 && t <= vcount && !vseen[t])
                    heap_add(t, arc_wt[e - 1]);
                e = arc_nxt[e - 1];
            end
        end
        r.cost = sum[25:0];
        r.nc   = (left != 0);
        r.ovf  = dropped;
        return r;
    endfunction

    initial
    begin
        fails   = 0;
        pending = 0;
        vcount  = prim_mst_pkg::VC_RESET;
        wipe_graph();
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready
                && paddr[prim_mst_pkg::ADDR_W-1:2] == prim_mst_pkg::REG_VERTEX_COUNT)
                vcount = pwdata[9:0];

            if (out_valid && !out_stall)
            begin
                if (tree_q.size() == 0)
                    report("unexpected result, total_cost", total_cost, 0);
                else
                begin
                    tree_result_t want;
                    want = tree_q.pop_front();
                    if (total_cost !== want.cost)
                        report("total_cost", total_cost, want.cost);
                    if (not_connected !== want.nc)
                        report("not_connected", not_connected, want.nc);
                    if (edge_overflow !== want.ovf)
                        report("edge_overflow", edge_overflow, want.ovf);
                end
            end

            if (in_valid && !in_stall)
            begin
                if (edge_valid)
                begin
                    if (n_edges >= NUM_EDGES)
                        dropped = 1;
                    else
                    begin
                        add_arc(endpoint_a, endpoint_b, weight, 2 * n_edges);
                        add_arc(endpoint_b, endpoint_a, weight, 2 * n_edges + 1);
                        n_edges++;
                    end
                end
                if (last_edge)
                begin
                    tree_q.insert(tree_q.size(), span_tree());
                    wipe_graph();
                end
            end
            pending = tree_q.size();
        end
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

    logic                              clk;
    logic                              rst_n;
    logic                              in_valid;
    logic                              in_stall;
    logic                              edge_valid;
    logic [9:0]                        endpoint_a;
    logic [9:0]                        endpoint_b;
    logic signed [15:0]                weight;
    logic                              last_edge;
    logic                              out_valid;
    logic                              out_stall;
    logic signed [25:0]                total_cost;
    logic                              not_connected;
    logic                              edge_overflow;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [prim_mst_pkg::ADDR_W-1:0]   paddr;
    logic [prim_mst_pkg::DATA_W-1:0]   pwdata;
    logic [prim_mst_pkg::DATA_W-1:0]   prdata;
    logic                              pready;
    int                                fails;
    int                                pending;
    bit                                calm;
    bit                                hold_rx;
    int                                hold_left;
    int unsigned                       vc_now;

    prim_mst_weight_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .edge_valid    (edge_valid),
        .endpoint_a    (endpoint_a),
        .endpoint_b    (endpoint_b),
        .weight        (weight),
        .last_edge     (last_edge),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .total_cost    (total_cost),
        .not_connected (not_connected),
        .edge_overflow (edge_overflow),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    prim_mst_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .edge_valid    (edge_valid),
        .endpoint_a    (endpoint_a),
        .endpoint_b    (endpoint_b),
        .weight        (weight),
        .last_edge     (last_edge),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .total_cost    (total_cost),
        .not_connected (not_connected),
        .edge_overflow (edge_overflow),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .fails         (fails),
        .pending       (pending)
    );

    initial
        clk = 1'b0;

    always #10 clk = ~clk;

    initial
    begin
        #40ms;
        $display("** prim_mst_weight_core: FAILED **");
        $finish;
    end

    // receiver: random stalls, plus one long hold when asked
    initial
    begin
        out_stall = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_rx)
            begin
                hold_rx = 0;
                hold_left = 3000;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !calm && $urandom_range(99) < 18;
        end
    end

    task automatic reg_write(input logic [prim_mst_pkg::ADDR_W-1:0] addr,
                             input logic [prim_mst_pkg::DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_vcount(input int unsigned vc);
        vc_now = vc;
        reg_write(3'(prim_mst_pkg::REG_VERTEX_COUNT) << 2, vc);
    endtask

    // stop offering, wait for every result, then for the clearing sweep
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (1200) @(posedge clk);
    endtask

    task automatic send(input bit ev, input int unsigned a, input int unsigned b,
                        input int w, input bit lst);
        while (!calm && $urandom_range(99) < 18)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        edge_valid <= ev;
        endpoint_a <= 10'(a);
        endpoint_b <= 10'(b);
        weight     <= 16'(w);
        last_edge  <= lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    function automatic int unsigned pick_vtx();
        int unsigned top;
        top = (vc_now + 1 > 1023) ? 1023 : vc_now + 1;
        if ($urandom_range(9) == 0)
            return $urandom_range(1023);
        return $urandom_range(top);
    endfunction

    task automatic rand_graph();
        int n;
        n = $urandom_range(15);
        for (int i = 0; i < n; i++)
            send($urandom_range(9) != 0, pick_vtx(), pick_vtx(), $urandom, 1'b0);
        send(1'($urandom_range(1)), pick_vtx(), pick_vtx(), $urandom, 1'b1);
    endtask

    initial
    begin
        int unsigned vc;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        edge_valid = 1'b0;
        endpoint_a = '0;
        endpoint_b = '0;
        weight     = '0;
        last_edge  = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        calm       = 0;
        hold_rx    = 0;
        vc_now     = prim_mst_pkg::VC_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (1200) @(posedge clk);

        // directed
        reg_write(3'd4, 32'hFFFF_FFFF);
        set_vcount(0);
        send(1'b1, 1, 2, 9, 1'b1);
        drain();
        set_vcount(1);
        send(1'b0, 0, 0, 0, 1'b1);
        drain();
        set_vcount(1023);
        send(1'b1, 1, 1023, -32768, 1'b0);
        send(1'b1, 0, 2, 32767, 1'b0);
        send(1'b1, 1, 1, 5, 1'b0);
        send(1'b1, 1, 2, 7, 1'b0);
        send(1'b1, 2, 1, -3, 1'b0);
        send(1'b0, 1023, 1023, -1, 1'b0);
        send(1'b1, 2, 1023, 32767, 1'b1);
        drain();
        set_vcount(3);
        send(1'b1, 1, 2, -32768, 1'b0);
        send(1'b1, 2, 3, 32767, 1'b0);
        send(1'b1, 3, 1, 0, 1'b0);
        send(1'b1, 3, 4, 1, 1'b0);
        send(1'b0, 0, 0, 0, 1'b1);
        drain();

        // full edge store: later edges dropped
        set_vcount(2);
        send(1'b1, 1, 2, 5, 1'b0);
        for (int i = 0; i < 4098; i++)
            send(1'b1, 1000, 1001, $urandom, 1'b0);
        send(1'b1, 1, 2, 4, 1'b1);
        drain();

        for (int ph = 0; ph < 30; ph++)
        begin
            case (ph)
                0:       vc = 1023;
                1:       vc = 1;
                2:       vc = 0;
                default: vc = ($urandom_range(7) == 0) ? $urandom_range(1023)
                                                       : $urandom_range(1, 12);
            endcase
            if ($urandom_range(3) == 0)
                reg_write(3'd4, $urandom);
            set_vcount(vc);
            calm = (ph >= 20 && ph <= 22);
            for (int g = 0; g < 5; g++)
            begin
                if (ph == 10 && g == 1)
                    hold_rx = 1;
                rand_graph();
            end
            drain();
        end

        drain();
        if (fails == 0)
            $display("** prim_mst_weight_core: PASSED **");
        else
            $display("** prim_mst_weight_core: FAILED **");
        $finish;
    end

endmodule

// File: sim.f
rtl/prim_mst_pkg.sv
rtl/prim_mst_ctrl.sv
rtl/prim_mst_dp.sv
rtl/prim_mst_weight_core.sv
rtl/prim_mst_chk.sv
tb/prim_mst_checker.sv
tb/testbench.sv
